// ===== rtl/sere_pkg.sv =====
// Shared types and codes for the sprite edge run extractor.
// No dependencies; imported by the top level.
package sere_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD,
    ST_SEEK,
    ST_TEST
  } st_t;

  // Walker mode during a fetch
  typedef enum logic [1:0] {
    MODE_FIND,
    MODE_EXTEND,
    MODE_LOOK
  } mode_t;

  // Command codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_ALPHA_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_IMAGE_WIDTH     = 2'd1;
  localparam logic [1:0] CFG_IMAGE_HEIGHT    = 2'd2;

  // Facing codes
  localparam logic [1:0] FACE_UP    = 2'd0;
  localparam logic [1:0] FACE_DOWN  = 2'd1;
  localparam logic [1:0] FACE_LEFT  = 2'd2;
  localparam logic [1:0] FACE_RIGHT = 2'd3;

endpackage

// ===== rtl/sere_map.sv =====
// Opacity map: one write port and two registered read ports.
// No dependencies.
module sere_map #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output logic          rd_data_a,
  output logic          rd_data_b
);

  logic mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read ports, data registered
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ===== rtl/sere_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// No dependencies; used to rebuild the load column and row after a width change.
module sere_div #(
  parameter int CW = 9,
  parameter int DW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [CW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [DW-1:0] remainder
);

  localparam int CNW = $clog2(CW + 1);

  logic [DW-1:0]  rem_r, rem_nxt;
  logic [CW-1:0]  dq_r, dq_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           run_r, run_nxt;
  logic           done_r, done_nxt;
  logic [DW:0]    shifted;
  logic [DW:0]    diff;
  logic           ge;

  // one restoring step
  always_comb begin
    shifted = {rem_r, dq_r[CW-1]};
    ge      = shifted >= {1'b0, divisor};
    diff    = shifted - {1'b0, divisor};
  end

  always_comb begin
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      dq_nxt  = dividend;
      cnt_nxt = CNW'(CW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = ge ? diff[DW-1:0] : shifted[DW-1:0];
      dq_nxt  = (dq_r << 1) | CW'(ge);
      cnt_nxt = cnt_r - CNW'(1);
      if (cnt_r == CNW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
  end

  assign done      = done_r;
  assign quotient  = DW'(dq_r);
  assign remainder = rem_r;

endmodule

// ===== rtl/sprite_edge_run_extractor.sv =====
// Sprite edge run extractor top level: sequencer, pixel walker and config registers.
// Depends on sere_pkg, sere_map and sere_div.
//
// A load (in_opcode 0) stores one pixel's opacity in row-major order; the first
// load after a width write waits while a serial divider rebuilds the column and
// row from the linear load count, unless that count has already reached the image
// size. A fetch (in_opcode 1) walks the outline with one map lookup (pixel and
// neighbor) per pixel tested, covering the run itself and the look-ahead to the
// next edge pixel that decides out_final_face. A fetch with nothing left answers
// in the cycle after it is taken. Each result is on the out_ ports for one cycle
// marked by out_strobe and cannot be held off; busy is high while an item is in
// work, and start is only taken while busy is low.
module sprite_edge_run_extractor
  import sere_pkg::*;
#(
  parameter int MAX_WIDTH  = 16,
  parameter int MAX_HEIGHT = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_opcode,
  input  logic [7:0] in_pixel_alpha,
  output logic       out_strobe,
  output logic       out_face_valid,
  output logic [1:0] out_facing,
  output logic [3:0] out_line_index,
  output logic [3:0] out_run_first,
  output logic [3:0] out_run_end,
  output logic       out_final_face,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DW    = $clog2(MAXD + 1);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  st_t   state_r, state_nxt;
  mode_t mode_r, mode_nxt;

  // configuration
  logic [7:0] alpha_threshold_r, alpha_threshold_nxt;
  logic [4:0] image_width_r, image_width_nxt;
  logic [4:0] image_height_r, image_height_nxt;

  // load position
  logic [CW-1:0] load_count_r, load_count_nxt;
  logic [DW-1:0] ld_x_r, ld_x_nxt;
  logic [DW-1:0] ld_y_r, ld_y_nxt;
  logic          geo_ok_r, geo_ok_nxt;
  logic          ld_opq_r, ld_opq_nxt;

  // scan resume point
  logic [1:0]    scan_facing_r, scan_facing_nxt;
  logic [DW-1:0] scan_line_r, scan_line_nxt;
  logic [DW-1:0] scan_pos_r, scan_pos_nxt;
  logic          scan_done_r, scan_done_nxt;

  // walker
  logic [1:0]    wf_r, wf_nxt;
  logic [DW-1:0] wl_r, wl_nxt;
  logic [DW-1:0] wp_r, wp_nxt;
  logic [DW-1:0] run_first_r, run_first_nxt;
  logic [DW-1:0] run_end_r, run_end_nxt;
  logic          nb_out_r, nb_out_nxt;

  // result registers
  logic       out_strobe_r, out_strobe_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_facing_r, out_facing_nxt;
  logic [3:0] out_line_r, out_line_nxt;
  logic [3:0] out_first_r, out_first_nxt;
  logic [3:0] out_end_r, out_end_nxt;
  logic       out_final_r, out_final_nxt;

  // geometry
  logic [DW-1:0] eff_w, eff_h, lines, len_v;
  logic [CW-1:0] total, count_inc;
  logic          count_over, inc_over;
  logic          line_over, pos_over, last_face;

  // pixel and neighbor
  logic [DW-1:0] cur_x, cur_y, nb_x, nb_y;
  logic          nb_out;
  logic [AW-1:0] cur_addr, nb_addr, wr_addr;
  logic          map_we;
  logic          rd_opq, rd_nb;
  logic          test_edge;

  // divider
  logic          div_start, div_done;
  logic [DW-1:0] div_quo, div_rem;

  // effective size, clamped to 1..MAX
  always_comb begin
    eff_w = (image_width_r == '0) ? DW'(1) :
            (32'(image_width_r) > MAX_WIDTH) ? DW'(MAX_WIDTH) : DW'(image_width_r);
    eff_h = (image_height_r == '0) ? DW'(1) :
            (32'(image_height_r) > MAX_HEIGHT) ? DW'(MAX_HEIGHT) : DW'(image_height_r);
    total      = CW'(32'(eff_w) * 32'(eff_h));
    count_inc  = load_count_r + CW'(1);
    count_over = load_count_r >= total;
    inc_over   = count_inc >= total;
  end

  // walker bounds: rows for up/down, columns for left/right
  always_comb begin
    lines     = wf_r[1] ? eff_w : eff_h;
    len_v     = wf_r[1] ? eff_h : eff_w;
    line_over = wl_r >= lines;
    pos_over  = wp_r >= len_v;
    last_face = wf_r == FACE_RIGHT;
    cur_x     = wf_r[1] ? wl_r : wp_r;
    cur_y     = wf_r[1] ? wp_r : wl_r;
  end

  // neighbor in the facing direction; clamped onto the pixel when outside
  always_comb begin
    nb_x   = cur_x;
    nb_y   = cur_y;
    nb_out = 1'b0;
    unique case (wf_r)
      FACE_UP: begin
        nb_out = cur_y == '0;
        if (!nb_out) nb_y = cur_y - DW'(1);
      end
      FACE_DOWN: begin
        nb_out = DW'(cur_y + DW'(1)) >= eff_h;
        if (!nb_out) nb_y = cur_y + DW'(1);
      end
      FACE_LEFT: begin
        nb_out = cur_x == '0;
        if (!nb_out) nb_x = cur_x - DW'(1);
      end
      FACE_RIGHT: begin
        nb_out = DW'(cur_x + DW'(1)) >= eff_w;
        if (!nb_out) nb_x = cur_x + DW'(1);
      end
    endcase
  end

  // map addresses
  always_comb begin
    cur_addr = AW'(32'(cur_y) * MAX_WIDTH + 32'(cur_x));
    nb_addr  = AW'(32'(nb_y) * MAX_WIDTH + 32'(nb_x));
    wr_addr  = AW'(32'(ld_y_r) * MAX_WIDTH + 32'(ld_x_r));
  end

  assign test_edge = rd_opq & (nb_out_r | ~rd_nb);

  sere_map #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_map (
    .clk       (clk),
    .wr_en     (map_we),
    .wr_addr   (wr_addr),
    .wr_data   (ld_opq_r),
    .rd_addr_a (cur_addr),
    .rd_addr_b (nb_addr),
    .rd_data_a (rd_opq),
    .rd_data_b (rd_nb)
  );

  sere_div #(
    .CW (CW),
    .DW (DW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (load_count_r),
    .divisor   (eff_w),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_opcode == OP_LOAD) begin
            state_nxt = (count_over || geo_ok_r) ? ST_LOAD : ST_DIV;
          end else if (!scan_done_r) begin
            state_nxt = ST_SEEK;
          end
        end
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_LOAD;
      end
      ST_LOAD: state_nxt = ST_IDLE;
      ST_SEEK: begin
        if (mode_r == MODE_EXTEND) begin
          state_nxt = pos_over ? ST_SEEK : ST_TEST;
        end else if (line_over) begin
          state_nxt = last_face ? ST_IDLE : ST_SEEK;
        end else begin
          state_nxt = pos_over ? ST_SEEK : ST_TEST;
        end
      end
      ST_TEST: begin
        state_nxt = (mode_r == MODE_LOOK && test_edge) ? ST_IDLE : ST_SEEK;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mode_nxt            = mode_r;
    alpha_threshold_nxt = alpha_threshold_r;
    image_width_nxt     = image_width_r;
    image_height_nxt    = image_height_r;
    load_count_nxt      = load_count_r;
    ld_x_nxt            = ld_x_r;
    ld_y_nxt            = ld_y_r;
    geo_ok_nxt          = geo_ok_r;
    ld_opq_nxt          = ld_opq_r;
    scan_facing_nxt     = scan_facing_r;
    scan_line_nxt       = scan_line_r;
    scan_pos_nxt        = scan_pos_r;
    scan_done_nxt       = scan_done_r;
    wf_nxt              = wf_r;
    wl_nxt              = wl_r;
    wp_nxt              = wp_r;
    run_first_nxt       = run_first_r;
    run_end_nxt         = run_end_r;
    nb_out_nxt          = nb_out_r;
    out_strobe_nxt      = 1'b0;
    out_valid_nxt       = out_valid_r;
    out_facing_nxt      = out_facing_r;
    out_line_nxt        = out_line_r;
    out_first_nxt       = out_first_r;
    out_end_nxt         = out_end_r;
    out_final_nxt       = out_final_r;
    div_start           = 1'b0;
    map_we              = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_opcode == OP_LOAD) begin
            ld_opq_nxt = in_pixel_alpha >= alpha_threshold_r;
            if (count_over) begin
              load_count_nxt = '0;
              ld_x_nxt       = '0;
              ld_y_nxt       = '0;
              geo_ok_nxt     = 1'b1;
            end else if (!geo_ok_r) begin
              div_start = 1'b1;
            end
          end else if (scan_done_r) begin
            // nothing left: empty result
            out_strobe_nxt = 1'b1;
            out_valid_nxt  = 1'b0;
            out_facing_nxt = '0;
            out_line_nxt   = '0;
            out_first_nxt  = '0;
            out_end_nxt    = '0;
            out_final_nxt  = 1'b0;
          end else begin
            wf_nxt   = scan_facing_r;
            wl_nxt   = scan_line_r;
            wp_nxt   = scan_pos_r;
            mode_nxt = MODE_FIND;
          end
        end
      end

      ST_DIV: begin
        if (div_done) begin
          ld_x_nxt   = div_rem;
          ld_y_nxt   = div_quo;
          geo_ok_nxt = 1'b1;
        end
      end

      ST_LOAD: begin
        // store pixel, advance load position, restart the scan
        map_we = 1'b1;
        if (inc_over) begin
          load_count_nxt = '0;
          ld_x_nxt       = '0;
          ld_y_nxt       = '0;
        end else begin
          load_count_nxt = count_inc;
          if (DW'(ld_x_r + DW'(1)) == eff_w) begin
            ld_x_nxt = '0;
            ld_y_nxt = ld_y_r + DW'(1);
          end else begin
            ld_x_nxt = ld_x_r + DW'(1);
          end
        end
        scan_facing_nxt = '0;
        scan_line_nxt   = '0;
        scan_pos_nxt    = '0;
        scan_done_nxt   = 1'b0;
      end

      ST_SEEK: begin
        unique case (mode_r)
          MODE_EXTEND: begin
            if (pos_over) begin
              // run reaches the end of the line
              run_end_nxt     = wp_r - DW'(1);
              scan_facing_nxt = wf_r;
              scan_line_nxt   = wl_r;
              scan_pos_nxt    = wp_r;
              mode_nxt        = MODE_LOOK;
            end else begin
              nb_out_nxt = nb_out;
            end
          end
          MODE_FIND, MODE_LOOK: begin
            if (line_over) begin
              if (last_face) begin
                // walk exhausted
                scan_done_nxt  = 1'b1;
                out_strobe_nxt = 1'b1;
                if (mode_r == MODE_FIND) begin
                  out_valid_nxt  = 1'b0;
                  out_facing_nxt = '0;
                  out_line_nxt   = '0;
                  out_first_nxt  = '0;
                  out_end_nxt    = '0;
                  out_final_nxt  = 1'b0;
                end else begin
                  out_valid_nxt  = 1'b1;
                  out_facing_nxt = scan_facing_r;
                  out_line_nxt   = 4'(scan_line_r);
                  out_first_nxt  = 4'(run_first_r);
                  out_end_nxt    = 4'(run_end_r);
                  out_final_nxt  = 1'b1;
                end
              end else begin
                wf_nxt = wf_r + 2'd1;
                wl_nxt = '0;
                wp_nxt = '0;
              end
            end else if (pos_over) begin
              wl_nxt = wl_r + DW'(1);
              wp_nxt = '0;
            end else begin
              nb_out_nxt = nb_out;
            end
          end
          default: ;
        endcase
      end

      ST_TEST: begin
        unique case (mode_r)
          MODE_FIND: begin
            if (test_edge) begin
              run_first_nxt = wp_r;
              mode_nxt      = MODE_EXTEND;
            end
            wp_nxt = wp_r + DW'(1);
          end
          MODE_EXTEND: begin
            if (test_edge) begin
              wp_nxt = wp_r + DW'(1);
            end else begin
              run_end_nxt     = wp_r - DW'(1);
              scan_facing_nxt = wf_r;
              scan_line_nxt   = wl_r;
              scan_pos_nxt    = wp_r;
              mode_nxt        = MODE_LOOK;
            end
          end
          MODE_LOOK: begin
            if (test_edge) begin
              // another run follows
              out_strobe_nxt = 1'b1;
              out_valid_nxt  = 1'b1;
              out_facing_nxt = scan_facing_r;
              out_line_nxt   = 4'(scan_line_r);
              out_first_nxt  = 4'(run_first_r);
              out_end_nxt    = 4'(run_end_r);
              out_final_nxt  = 1'b0;
            end else begin
              wp_nxt = wp_r + DW'(1);
            end
          end
          default: ;
        endcase
      end

      default: ;
    endcase

    // configuration writes
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALPHA_THRESHOLD: alpha_threshold_nxt = cfg_data;
        CFG_IMAGE_WIDTH: begin
          image_width_nxt = cfg_data[4:0];
          geo_ok_nxt      = 1'b0;
        end
        CFG_IMAGE_HEIGHT: image_height_nxt = cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      alpha_threshold_r <= 8'd1;
      image_width_r     <= 5'd16;
      image_height_r    <= 5'd16;
      load_count_r      <= '0;
      ld_x_r            <= '0;
      ld_y_r            <= '0;
      geo_ok_r          <= 1'b1;
      scan_facing_r     <= '0;
      scan_line_r       <= '0;
      scan_pos_r        <= '0;
      scan_done_r       <= 1'b0;
      out_strobe_r      <= 1'b0;
      mode_r            <= MODE_FIND;
    end else begin
      state_r           <= state_nxt;
      alpha_threshold_r <= alpha_threshold_nxt;
      image_width_r     <= image_width_nxt;
      image_height_r    <= image_height_nxt;
      load_count_r      <= load_count_nxt;
      ld_x_r            <= ld_x_nxt;
      ld_y_r            <= ld_y_nxt;
      geo_ok_r          <= geo_ok_nxt;
      scan_facing_r     <= scan_facing_nxt;
      scan_line_r       <= scan_line_nxt;
      scan_pos_r        <= scan_pos_nxt;
      scan_done_r       <= scan_done_nxt;
      out_strobe_r      <= out_strobe_nxt;
      mode_r            <= mode_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ld_opq_r    <= ld_opq_nxt;
    wf_r        <= wf_nxt;
    wl_r        <= wl_nxt;
    wp_r        <= wp_nxt;
    run_first_r <= run_first_nxt;
    run_end_r   <= run_end_nxt;
    nb_out_r    <= nb_out_nxt;
    out_valid_r  <= out_valid_nxt;
    out_facing_r <= out_facing_nxt;
    out_line_r   <= out_line_nxt;
    out_first_r  <= out_first_nxt;
    out_end_r    <= out_end_nxt;
    out_final_r  <= out_final_nxt;
  end

  assign busy           = state_r != ST_IDLE;
  assign out_strobe     = out_strobe_r;
  assign out_face_valid = out_valid_r;
  assign out_facing     = out_facing_r;
  assign out_line_index = out_line_r;
  assign out_run_first  = out_first_r;
  assign out_run_end    = out_end_r;
  assign out_final_face = out_final_r;

endmodule

// ===== verif/sprite_edge_run_extractor_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sprite_edge_run_extractor: a directed table with expected
// rows, then random load/fetch phases checked against an in-bench run predictor. Needs rtl/sere_pkg.sv.
module sprite_edge_run_extractor_test;
  import sere_pkg::*;

  localparam int MAX_W         = 16;
  localparam int MAX_H         = 16;
  localparam int RANDOM_ITEMS  = 700;
  localparam int SETTLE_CYCLES = 32;
  localparam int CYCLE_LIMIT   = 2_000_000;

  // One fetch result as seen on the out_ ports
  typedef struct packed {
    logic       face_valid;
    logic [1:0] facing;
    logic [3:0] line_index;
    logic [3:0] run_first;
    logic [3:0] run_end;
    logic       final_face;
  } run_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_FETCH} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic [1:0] idx;
    logic [7:0] arg;
    bit         typed;
    run_t       want;
  } row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic       in_opcode;
  logic [7:0] in_pixel_alpha;
  logic       out_strobe;
  logic       out_face_valid;
  logic [1:0] out_facing;
  logic [3:0] out_line_index;
  logic [3:0] out_run_first;
  logic [3:0] out_run_end;
  logic       out_final_face;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  sprite_edge_run_extractor dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_pixel_alpha (in_pixel_alpha),
    .out_strobe     (out_strobe),
    .out_face_valid (out_face_valid),
    .out_facing     (out_facing),
    .out_line_index (out_line_index),
    .out_run_first  (out_run_first),
    .out_run_end    (out_run_end),
    .out_final_face (out_final_face),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted block state
  bit       pix_opaque  [MAX_W*MAX_H];
  bit       pix_written [MAX_W*MAX_H];
  int       load_pos;
  int       walk_facing, walk_line, walk_pos;
  bit       walk_done;
  bit [7:0] thr_reg;
  bit [4:0] width_reg, height_reg;

  run_t expected_runs[$];
  row_t plan[$];
  int   n_errors, n_loads, n_fetches, n_runs, n_items, n_phases;
  int   cycle_count;
  bit   calm;

  // ---------------------------------------------------------------- predictor

  function automatic int eff_dim(bit [4:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic bit opaque_px(int x, int y);
    if (x < 0 || y < 0 || x >= MAX_W || y >= MAX_H) return 1'b0;
    return pix_opaque[y*MAX_W + x];
  endfunction

  // Opaque pixel whose neighbor in direction f is clear or off the image
  function automatic bit edge_px(int f, int ln, int pos, int w, int h);
    int x, y;
    x = (f < 2) ? pos : ln;
    y = (f < 2) ? ln : pos;
    if (x >= w || y >= h || !opaque_px(x, y)) return 1'b0;
    case (f)
      FACE_UP:   return y == 0 || !opaque_px(x, y - 1);
      FACE_DOWN: return y + 1 >= h || !opaque_px(x, y + 1);
      FACE_LEFT: return x == 0 || !opaque_px(x - 1, y);
      default:   return x + 1 >= w || !opaque_px(x + 1, y);
    endcase
  endfunction

  // First run at or after (f, ln, pos) in facing/line/start order
  function automatic bit next_run(int f, int ln, int pos,
                                  output int rf, output int rl, output int ra, output int rb);
    int w, h, lines, len, beg;
    w  = eff_dim(width_reg, MAX_W);
    h  = eff_dim(height_reg, MAX_H);
    rf = 0; rl = 0; ra = 0; rb = 0;
    while (f < 4) begin
      lines = (f < 2) ? h : w;
      len   = (f < 2) ? w : h;
      while (ln < lines) begin
        while (pos < len) begin
          if (edge_px(f, ln, pos, w, h)) begin
            beg = pos;
            while (pos + 1 < len && edge_px(f, ln, pos + 1, w, h)) pos++;
            rf = f; rl = ln; ra = beg; rb = pos;
            return 1'b1;
          end
          pos++;
        end
        ln++;
        pos = 0;
      end
      f++;
      ln  = 0;
      pos = 0;
    end
    return 1'b0;
  endfunction

  function automatic void predict_load(logic [7:0] alpha);
    int w, h, total;
    w     = eff_dim(width_reg, MAX_W);
    h     = eff_dim(height_reg, MAX_H);
    total = w * h;
    if (load_pos >= total) load_pos = 0;
    pix_opaque[(load_pos / w)*MAX_W + load_pos % w]  = (alpha >= thr_reg);
    pix_written[(load_pos / w)*MAX_W + load_pos % w] = 1'b1;
    load_pos++;
    if (load_pos >= total) load_pos = 0;
    walk_facing = 0; walk_line = 0; walk_pos = 0; walk_done = 1'b0;
  endfunction

  function automatic run_t predict_fetch();
    int   f, l, a, b, f2, l2, a2, b2;
    run_t r;
    r = '0;
    if (walk_done || !next_run(walk_facing, walk_line, walk_pos, f, l, a, b)) begin
      walk_done = 1'b1;
      return r;
    end
    walk_facing  = f;
    walk_line    = l;
    walk_pos     = b + 1;
    r.face_valid = 1'b1;
    r.facing     = f[1:0];
    r.line_index = l[3:0];
    r.run_first  = a[3:0];
    r.run_end    = b[3:0];
    if (!next_run(f, l, b + 1, f2, l2, a2, b2)) begin
      r.final_face = 1'b1;
      walk_done    = 1'b1;
    end
    return r;
  endfunction

  // Every pixel a fetch can read at the current size has been loaded
  function automatic bit map_ready();
    int w, h;
    w = eff_dim(width_reg, MAX_W);
    h = eff_dim(height_reg, MAX_H);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        if (!pix_written[y*MAX_W + x]) return 1'b0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- table rows

  function automatic run_t mk_run(logic v, logic [1:0] f, logic [3:0] l, logic [3:0] a,
                                  logic [3:0] b, logic fin);
    run_t r;
    r.face_valid = v; r.facing = f; r.line_index = l;
    r.run_first  = a; r.run_end = b; r.final_face = fin;
    return r;
  endfunction

  function automatic row_t mk_row(row_kind_e kind, logic [1:0] idx, logic [7:0] arg,
                                  bit typed, run_t want);
    row_t r;
    r.kind = kind; r.idx = idx; r.arg = arg; r.typed = typed; r.want = want;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic note_mismatch(string msg);
    n_errors++;
    if (n_errors <= 40) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) note_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Each strobed result is matched against the oldest pending fetch
  always @(posedge clk) begin : result_check
    run_t want;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (expected_runs.size() == 0) begin
        note_mismatch("result with no fetch pending");
      end else begin
        want = expected_runs.pop_front();
        check_field("face_valid", out_face_valid, want.face_valid);
        check_field("facing",     out_facing,     want.facing);
        check_field("line_index", out_line_index, want.line_index);
        check_field("run_first",  out_run_first,  want.run_first);
        check_field("run_end",    out_run_end,    want.run_end);
        check_field("final_face", out_final_face, want.final_face);
        if (out_face_valid === 1'b1) n_runs++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------- driving

  // One transfer on the command port; called and returns at a falling edge
  task automatic send_item(logic op, logic [7:0] alpha, bit typed, run_t want,
                           output run_t got);
    start          <= 1'b1;
    in_opcode      <= op;
    in_pixel_alpha <= alpha;
    while (busy === 1'b1) @(negedge clk);
    @(posedge clk);
    got = '0;
    if (op == OP_LOAD) begin
      predict_load(alpha);
      n_loads++;
    end else begin
      got = predict_fetch();
      expected_runs.push_back(typed ? want : got);
      n_fetches++;
    end
    n_items++;
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int r, n;
    r = $urandom_range(99);
    if (calm || r < 60) n = 0;
    else if (r < 90)    n = $urandom_range(3, 1);
    else if (r < 98)    n = $urandom_range(12, 4);
    else                n = $urandom_range(60, 20);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_ALPHA_THRESHOLD: thr_reg    = data;
      CFG_IMAGE_WIDTH:     width_reg  = data[4:0];
      CFG_IMAGE_HEIGHT:    height_reg = data[4:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Wait out pending fetches, then the tail of any trailing load
  task automatic settle();
    start <= 1'b0;
    while (expected_runs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (busy === 1'b1) @(negedge clk);
  endtask

  // Load with an alpha that mostly lands on the chosen side of the threshold
  task automatic issue_load(int dens);
    logic [7:0] a;
    run_t       got;
    bit         want_opaque, near;
    want_opaque = ($urandom_range(99) < dens);
    near        = $urandom_range(1);
    if ($urandom_range(4) == 0)  a = 8'($urandom);
    else if (want_opaque)        a = near ? thr_reg : 8'($urandom_range(255, thr_reg));
    else if (thr_reg == 0)       a = 8'($urandom);
    else                         a = near ? thr_reg - 8'd1 : 8'($urandom_range(thr_reg - 1, 0));
    send_item(OP_LOAD, a, 1'b0, '0, got);
    idle_gap();
  endtask

  task automatic issue_fetch(output run_t got);
    send_item(OP_FETCH, 8'($urandom), 1'b0, '0, got);
    idle_gap();
  endtask

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    run_t got;
    bit   prev_cfg;
    int   base_items, w, h, dens, mode, fetch_cap, restarts;
    logic [4:0] wsel, hsel;
    logic [7:0] tsel;

    rst_n = 1'b0; start = 1'b0; in_opcode = OP_LOAD; in_pixel_alpha = 8'd0;
    cfg_we = 1'b0; cfg_index = CFG_ALPHA_THRESHOLD; cfg_data = 8'd0;
    cycle_count = 0;
    thr_reg = 8'd1; width_reg = 5'd16; height_reg = 5'd16;
    load_pos = 0; walk_facing = 0; walk_line = 0; walk_pos = 0; walk_done = 1'b0;
    foreach (pix_written[i]) begin
      pix_written[i] = 1'b0;
      pix_opaque[i]  = 1'b0;
    end

    // 1x1 image at the top threshold; also a write to the unused index
    plan.push_back(mk_row(ROW_CFG, CFG_ALPHA_THRESHOLD, 8'd255, 1'b0, '0));
    plan.push_back(mk_row(ROW_CFG, CFG_IMAGE_WIDTH, 8'd1, 1'b0, '0));
    plan.push_back(mk_row(ROW_CFG, CFG_IMAGE_HEIGHT, 8'd1, 1'b0, '0));
    plan.push_back(mk_row(ROW_CFG, 2'd3, 8'hA5, 1'b0, '0));
    plan.push_back(mk_row(ROW_LOAD, 2'd0, 8'd255, 1'b0, '0));
    plan.push_back(mk_row(ROW_FETCH, 2'd0, 8'd0, 1'b1, mk_run(1, FACE_UP, 0, 0, 0, 0)));
    plan.push_back(mk_row(ROW_FETCH, 2'd0, 8'd0, 1'b1, mk_run(1, FACE_DOWN, 0, 0, 0, 0)));
    plan.push_back(mk_row(ROW_FETCH, 2'd0, 8'd0, 1'b1, mk_run(1, FACE_LEFT, 0, 0, 0, 0)));
    plan.push_back(mk_row(ROW_FETCH, 2'd0, 8'd0, 1'b1, mk_run(1, FACE_RIGHT, 0, 0, 0, 1)));
    // exhausted scan, then a clear pixel just under threshold
    plan.push_back(mk_row(ROW_FETCH, 2'd0, 8'd0, 1'b1, '0));
    plan.push_back(mk_row(ROW_LOAD, 2'd0, 8'd254, 1'b0, '0));
    plan.push_back(mk_row(ROW_FETCH, 2'd0, 8'd0, 1'b1, '0));
    // zero threshold: a solid 3x2 block
    plan.push_back(mk_row(ROW_CFG, CFG_ALPHA_THRESHOLD, 8'd0, 1'b0, '0));
    plan.push_back(mk_row(ROW_CFG, CFG_IMAGE_WIDTH, 8'd3, 1'b0, '0));
    plan.push_back(mk_row(ROW_CFG, CFG_IMAGE_HEIGHT, 8'd2, 1'b0, '0));
    repeat (6) plan.push_back(mk_row(ROW_LOAD, 2'd0, 8'd0, 1'b0, '0));
    plan.push_back(mk_row(ROW_FETCH, 2'd0, 8'd0, 1'b1, mk_run(1, FACE_UP, 0, 0, 2, 0)));
    plan.push_back(mk_row(ROW_FETCH, 2'd0, 8'd0, 1'b1, mk_run(1, FACE_DOWN, 1, 0, 2, 0)));
    plan.push_back(mk_row(ROW_FETCH, 2'd0, 8'd0, 1'b1, mk_run(1, FACE_LEFT, 0, 0, 1, 0)));
    plan.push_back(mk_row(ROW_FETCH, 2'd0, 8'd0, 1'b1, mk_run(1, FACE_RIGHT, 2, 0, 1, 1)));
    // mid threshold, checkerboard 2x2 straddling it
    plan.push_back(mk_row(ROW_CFG, CFG_ALPHA_THRESHOLD, 8'd128, 1'b0, '0));
    plan.push_back(mk_row(ROW_CFG, CFG_IMAGE_WIDTH, 8'd2, 1'b0, '0));
    plan.push_back(mk_row(ROW_LOAD, 2'd0, 8'd127, 1'b0, '0));
    plan.push_back(mk_row(ROW_LOAD, 2'd0, 8'd128, 1'b0, '0));
    plan.push_back(mk_row(ROW_LOAD, 2'd0, 8'd255, 1'b0, '0));
    plan.push_back(mk_row(ROW_LOAD, 2'd0, 8'd0, 1'b0, '0));
    repeat (4) plan.push_back(mk_row(ROW_FETCH, 2'd0, 8'd0, 1'b0, '0));

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table
    prev_cfg = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (!prev_cfg) settle();
        write_reg(plan[i].idx, plan[i].arg);
        prev_cfg = 1'b1;
      end else begin
        if (prev_cfg) cfg_we <= 1'b0;
        prev_cfg = 1'b0;
        send_item(plan[i].kind == ROW_FETCH ? OP_FETCH : OP_LOAD, plan[i].arg,
                  plan[i].typed, plan[i].want, got);
        idle_gap();
      end
    end

    // Random phases: new settings, mostly a full image load then a scan drain
    base_items = n_items;
    while (n_items - base_items < RANDOM_ITEMS) begin
      settle();
      case (n_phases)
        0:       begin wsel = 5'd16; hsel = 5'd16; end
        1:       begin wsel = 5'd16; hsel = 5'd1;  end
        2:       begin wsel = 5'd1;  hsel = 5'd16; end
        3:       begin wsel = 5'd0;  hsel = 5'd31; end
        default: begin
          case ($urandom_range(9))
            0:       begin wsel = 5'd16; hsel = 5'($urandom_range(3, 1)); end
            1:       begin wsel = 5'($urandom_range(3, 1)); hsel = 5'd16; end
            2:       begin wsel = 5'($urandom_range(31, 17)); hsel = 5'($urandom_range(2, 0)); end
            default: begin wsel = 5'($urandom_range(6, 1)); hsel = 5'($urandom_range(6, 1)); end
          endcase
        end
      endcase
      case ($urandom_range(5))
        0:       tsel = 8'd0;
        1:       tsel = 8'd255;
        2:       tsel = 8'd1;
        3:       tsel = 8'd128;
        default: tsel = 8'($urandom);
      endcase
      if (n_phases < 4 || $urandom_range(3) != 0) write_reg(CFG_ALPHA_THRESHOLD, tsel);
      if (n_phases < 4 || $urandom_range(3) != 0)
        write_reg(CFG_IMAGE_WIDTH, {3'($urandom), wsel});
      if (n_phases < 4 || $urandom_range(3) != 0)
        write_reg(CFG_IMAGE_HEIGHT, {3'($urandom), hsel});
      cfg_we <= 1'b0;

      w     = eff_dim(width_reg, MAX_W);
      h     = eff_dim(height_reg, MAX_H);
      calm  = ($urandom_range(3) == 0);
      dens  = $urandom_range(100);
      mode  = (n_phases < 4) ? 0 : $urandom_range(9);
      fetch_cap = (w * h > 64) ? 40 : 60;

      if (mode == 9) begin
        // noise: loads and fetches mixed at random
        repeat ($urandom_range(20, 5)) begin
          if ($urandom_range(1) && map_ready()) issue_fetch(got);
          else issue_load(dens);
        end
      end else begin
        if (mode <= 6 || !map_ready()) repeat (w * h) issue_load(dens);
        else if (mode == 7) repeat ($urandom_range(w * h, 1)) issue_load(dens);
        // mode 8 keeps the scan where the last setting left it, unless the map is not ready
        restarts = 0;
        for (int k = 0; k < fetch_cap; k++) begin
          if (restarts < 2 && $urandom_range(24) == 0) begin
            issue_load(dens);
            restarts++;
          end
          if ($urandom_range(19) == 0 || (n_phases == 1 && k == 3)) begin
            // hold off until every pending fetch has answered
            start <= 1'b0;
            @(negedge clk);
            while (expected_runs.size() != 0) @(negedge clk);
          end
          issue_fetch(got);
          if (!got.face_valid) begin
            if ($urandom_range(2) == 0) issue_fetch(got);
            break;
          end
        end
      end
      n_phases++;
    end

    // Drain and finish
    start <= 1'b0;
    while (expected_runs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_runs.size() != 0)
      note_mismatch($sformatf("%0d fetches never answered", expected_runs.size()));
    $display("tb: %0d loads and %0d fetches over %0d random settings, %0d runs returned",
             n_loads, n_fetches, n_phases, n_runs);
    if (n_errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
